FILE: hw/rtl/ogpd_pkg.sv
package ogpd_pkg;

    localparam int MAX_POINTS_DEF = 64;

    // result kinds
    localparam logic [1:0] KIND_POINT    = 2'd0;
    localparam logic [1:0] KIND_BOX      = 2'd1;
    localparam logic [1:0] KIND_COMPOUND = 2'd2;
    localparam logic [1:0] KIND_OVERFLOW = 2'd3;

    // controller states; the byte-taking ones double as parse phase codes
    localparam logic [3:0] S_HEADER = 4'd0;
    localparam logic [3:0] S_ENDS   = 4'd1;
    localparam logic [3:0] S_INSLEN = 4'd2;
    localparam logic [3:0] S_SKIP   = 4'd3;
    localparam logic [3:0] S_FLAGS  = 4'd4;
    localparam logic [3:0] S_REPT   = 4'd5;
    localparam logic [3:0] S_XINIT  = 4'd6;
    localparam logic [3:0] S_XWAIT  = 4'd7;
    localparam logic [3:0] S_XCHK   = 4'd8;
    localparam logic [3:0] S_XS     = 4'd9;
    localparam logic [3:0] S_YINIT  = 4'd10;
    localparam logic [3:0] S_YWAIT  = 4'd11;
    localparam logic [3:0] S_YCHK   = 4'd12;
    localparam logic [3:0] S_YS     = 4'd13;
    localparam logic [3:0] S_CMPD   = 4'd14;
    localparam logic [3:0] S_DONE   = 4'd15;

    // datapath operations
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_BYTE  = 3'd1;
    localparam logic [2:0] OP_REPT  = 3'd2;
    localparam logic [2:0] OP_XRUN  = 3'd3;
    localparam logic [2:0] OP_YRUN  = 3'd4;
    localparam logic [2:0] OP_XINIT = 3'd5;
    localparam logic [2:0] OP_YINIT = 3'd6;
    localparam logic [2:0] OP_CMPD  = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic [3:0] phase;
        logic       clear;
    } ogpd_cmd_t;

    typedef struct packed {
        logic gs;
        logic hdr_done;
        logic neg;
        logic zero;
        logic ends_last;
        logic word_big;
        logic word_zero;
        logic second_byte;
        logic skip_one;
        logic rep_pend;
        logic flag_rep;
        logic flags_full;
        logic cur_ge;
        logic rep_zero;
        logic x_zero;
        logic y_zero;
        logic x_done;
        logic y_done;
        logic out_free;
    } ogpd_stat_t;

    // bit0 on curve, bit1 x short, bit2 y short, bit3 x same, bit4 y same
    function automatic logic [4:0] pack_flag(input logic [7:0] f);
        return {f[5], f[4], f[2], f[1], f[0]};
    endfunction

endpackage

FILE: hw/rtl/ogpd_if.sv
interface ogpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       glyph_start;

    modport source (output valid, output data_byte, output glyph_start, input ready);
    modport sink   (input valid, input data_byte, input glyph_start, output ready);
endinterface

interface ogpd_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] box_x_max;
    logic signed [15:0] box_y_max;
    logic               on_curve;
    logic               contour_end;
    logic [5:0]         point_index;
    logic               last;

    modport source (output valid, output kind, output coord_x, output coord_y,
                    output box_x_max, output box_y_max, output on_curve,
                    output contour_end, output point_index, output last, input ready);
    modport sink   (input valid, input kind, input coord_x, input coord_y,
                    input box_x_max, input box_y_max, input on_curve,
                    input contour_end, input point_index, input last, output ready);
endinterface

FILE: hw/rtl/outline_glyph_point_decoder_top.sv
// One byte per cycle in header, end-index, length, skip and flag phases while the output is
// free; a flag repeat expands one flag per cycle, then closes in a final step. A compound glyph adds
// a compound state that waits for a free output. x and y passes: a set-up state, then per point
// the wait and check states (cursor to registered flag/x data) plus its 0 to 2 bytes.
// Results are registered and appear in the cycle after the deciding byte or step; input stalls while one waits.
// Asynchronous reset (rst_n low) returns the parse to the header; stores undefined until written.
module outline_glyph_point_decoder_top #(
    parameter int MAX_POINTS = ogpd_pkg::MAX_POINTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    ogpd_byte_if.sink     glyph,
    ogpd_result_if.source result
);
    import ogpd_pkg::*;

    ogpd_cmd_t  cmd;
    ogpd_stat_t stat;

    ogpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (glyph.valid),
        .in_ready (glyph.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ogpd_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (glyph.data_byte),
        .glyph_start (glyph.glyph_start),
        .out_ready   (result.ready),
        .stat        (stat),
        .out_valid   (result.valid),
        .kind        (result.kind),
        .coord_x     (result.coord_x),
        .coord_y     (result.coord_y),
        .box_x_max   (result.box_x_max),
        .box_y_max   (result.box_y_max),
        .on_curve    (result.on_curve),
        .contour_end (result.contour_end),
        .point_index (result.point_index),
        .last        (result.last)
    );

endmodule

FILE: hw/rtl/ogpd_ctrl.sv
module ogpd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  ogpd_pkg::ogpd_stat_t   stat,
    output ogpd_pkg::ogpd_cmd_t    cmd
);
    import ogpd_pkg::*;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       accepting;
    logic [3:0] eff;

    always_comb
    begin
        accepting = state_reg inside {S_HEADER, S_ENDS, S_INSLEN, S_SKIP, S_FLAGS,
                                      S_XS, S_YS, S_DONE};
        in_ready  = accepting && stat.out_free;
        eff       = stat.gs ? S_HEADER : state_reg;
        cmd.op    = OP_NONE;
        cmd.phase = eff;
        cmd.clear = 1'b0;
        state_next = state_reg;
        if (in_ready && in_valid)
        begin
            cmd.op    = OP_BYTE;
            cmd.clear = stat.gs;
            case (eff)
                S_HEADER:
                begin
                    if (stat.hdr_done)
                    begin
                        if (stat.neg)
                            state_next = S_CMPD;
                        else if (stat.zero)
                            state_next = S_DONE;
                        else
                            state_next = S_ENDS;
                    end
                    else
                        state_next = S_HEADER;
                end
                S_ENDS:
                begin
                    if (stat.second_byte && stat.ends_last)
                        state_next = stat.word_big ? S_DONE : S_INSLEN;
                end
                S_INSLEN:
                begin
                    if (stat.second_byte)
                        state_next = stat.word_zero ? S_FLAGS : S_SKIP;
                end
                S_SKIP:
                begin
                    if (stat.skip_one)
                        state_next = S_FLAGS;
                end
                S_FLAGS:
                begin
                    if (stat.rep_pend)
                        state_next = S_REPT;
                    else if (!stat.flag_rep && stat.flags_full)
                        state_next = S_XINIT;
                end
                S_XS:
                begin
                    if (stat.x_done)
                        state_next = S_XWAIT;
                end
                S_YS:
                begin
                    if (stat.y_done)
                        state_next = S_YWAIT;
                end
                default:
                    state_next = state_reg;
            endcase
        end
        else
        begin
            case (state_reg)
                S_REPT:
                begin
                    cmd.op = OP_REPT;
                    if (stat.rep_zero)
                        state_next = stat.cur_ge ? S_XINIT : S_FLAGS;
                end
                S_XINIT:
                begin
                    cmd.op     = OP_XINIT;
                    state_next = S_XWAIT;
                end
                S_XWAIT:
                    state_next = S_XCHK;
                S_XCHK:
                begin
                    if (stat.cur_ge)
                        state_next = S_YINIT;
                    else if (stat.x_zero)
                    begin
                        cmd.op     = OP_XRUN;
                        state_next = S_XWAIT;
                    end
                    else
                        state_next = S_XS;
                end
                S_YINIT:
                begin
                    cmd.op     = OP_YINIT;
                    state_next = S_YWAIT;
                end
                S_YWAIT:
                    state_next = S_YCHK;
                S_YCHK:
                begin
                    if (stat.cur_ge)
                        state_next = S_DONE;
                    else if (stat.y_zero)
                    begin
                        if (stat.out_free)
                        begin
                            cmd.op     = OP_YRUN;
                            state_next = S_YWAIT;
                        end
                    end
                    else
                        state_next = S_YS;
                end
                S_CMPD:
                begin
                    if (stat.out_free)
                    begin
                        cmd.op     = OP_CMPD;
                        state_next = S_DONE;
                    end
                end
                default:
                    state_next = state_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_HEADER;
        else
            state_reg <= state_next;
    end

endmodule

FILE: hw/rtl/ogpd_dp.sv
module ogpd_dp #(
    parameter int MAX_POINTS = ogpd_pkg::MAX_POINTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ogpd_pkg::ogpd_cmd_t   cmd,
    input  logic [7:0]            data_byte,
    input  logic                  glyph_start,
    input  logic                  out_ready,
    output ogpd_pkg::ogpd_stat_t  stat,
    output logic                  out_valid,
    output logic [1:0]            kind,
    output logic signed [15:0]    coord_x,
    output logic signed [15:0]    coord_y,
    output logic signed [15:0]    box_x_max,
    output logic signed [15:0]    box_y_max,
    output logic                  on_curve,
    output logic                  contour_end,
    output logic [5:0]            point_index,
    output logic                  last
);
    import ogpd_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    logic [3:0]            fp_reg, fp_next;
    logic [7:0]            hold_reg, hold_next;
    logic [15:0]           contours_reg, contours_next;
    logic [CNT_W-1:0]      total_reg, total_next;
    logic [15:0]           skip_reg, skip_next;
    logic                  rep_pend_reg, rep_pend_next;
    logic [7:0]            rep_val_reg, rep_val_next;
    logic [CNT_W-1:0]      rep_cnt_reg, rep_cnt_next;
    logic [MAX_POINTS-1:0] end_mask_reg, end_mask_next;
    logic [15:0]           running_reg, running_next;
    logic [CNT_W-1:0]      cursor_reg, cursor_next;
    logic [15:0]           xmin_reg, xmin_next;
    logic [15:0]           ymin_reg, ymin_next;
    logic [15:0]           xmax_reg, xmax_next;

    logic [4:0]            flag_mem [MAX_POINTS];
    logic [15:0]           x_mem [MAX_POINTS];
    logic [4:0]            flag_q_reg;
    logic [15:0]           x_q_reg;

    logic                  flag_we, x_we;
    logic [4:0]            flag_wd;
    logic [15:0]           x_wd;

    logic                  out_valid_reg, out_valid_next, out_load, out_free;
    logic [1:0]            kind_reg, o_kind;
    logic [15:0]           cx_reg, cy_reg, xm_reg, ym_reg, o_x, o_y, o_xm, o_ym;
    logic                  on_reg, ce_reg, last_reg, o_on, o_ce, o_last;
    logic [5:0]            idx_reg, o_idx;

    logic [15:0]           word, dsum;
    logic                  d_short, d_pos;
    logic [IDX_W-1:0]      cursor_idx;
    logic [CNT_W-1:0]      cursor_inc, room, cursor_after;

    assign word       = {hold_reg, data_byte};
    assign cursor_idx = cursor_reg[IDX_W-1:0];
    assign cursor_inc = cursor_reg + CNT_W'(1);
    assign room       = total_reg - cursor_reg;
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        d_short = (cmd.phase == S_XS) ? flag_q_reg[1] : flag_q_reg[2];
        d_pos   = (cmd.phase == S_XS) ? flag_q_reg[3] : flag_q_reg[4];
        if (d_short)
            dsum = d_pos ? running_reg + {8'd0, data_byte} : running_reg - {8'd0, data_byte};
        else
            dsum = running_reg + word;
        cursor_after = (cursor_reg < total_reg) ? cursor_inc : cursor_reg;
    end

    always_comb
    begin
        stat.gs          = glyph_start;
        stat.hdr_done    = !glyph_start && (fp_reg == 4'd9);
        stat.neg         = contours_reg[15];
        stat.zero        = (contours_reg == 16'd0);
        stat.ends_last   = (contours_reg == 16'd1);
        stat.word_big    = (word >= 16'(MAX_POINTS));
        stat.word_zero   = (word == 16'd0);
        stat.second_byte = fp_reg[0];
        stat.skip_one    = (skip_reg == 16'd1);
        stat.rep_pend    = rep_pend_reg;
        stat.flag_rep    = data_byte[3];
        stat.flags_full  = (cursor_after >= total_reg);
        stat.cur_ge      = (cursor_reg >= total_reg);
        stat.rep_zero    = (rep_cnt_reg == '0);
        stat.x_zero      = ((flag_q_reg & 5'h0A) == 5'h08);
        stat.y_zero      = ((flag_q_reg & 5'h14) == 5'h10);
        stat.x_done      = flag_q_reg[1] || fp_reg[0];
        stat.y_done      = flag_q_reg[2] || fp_reg[0];
        stat.out_free    = out_free;
    end

    always_comb
    begin
        fp_next       = fp_reg;
        hold_next     = hold_reg;
        contours_next = contours_reg;
        total_next    = total_reg;
        skip_next     = skip_reg;
        rep_pend_next = rep_pend_reg;
        rep_val_next  = rep_val_reg;
        rep_cnt_next  = rep_cnt_reg;
        end_mask_next = end_mask_reg;
        running_next  = running_reg;
        cursor_next   = cursor_reg;
        xmin_next     = xmin_reg;
        ymin_next     = ymin_reg;
        xmax_next     = xmax_reg;
        flag_we       = 1'b0;
        flag_wd       = pack_flag(data_byte);
        x_we          = 1'b0;
        x_wd          = running_reg;
        out_load      = 1'b0;
        o_kind        = KIND_POINT;
        o_x           = x_q_reg;
        o_y           = running_reg;
        o_xm          = 16'd0;
        o_ym          = 16'd0;
        o_on          = flag_q_reg[0];
        o_ce          = end_mask_reg[cursor_idx];
        o_idx         = 6'(cursor_idx);
        o_last        = (cursor_inc == total_reg);

        case (cmd.op)
            OP_BYTE:
            begin
                if (cmd.clear)
                begin
                    fp_next       = 4'd1;
                    hold_next     = data_byte;
                    contours_next = 16'd0;
                    total_next    = '0;
                    skip_next     = 16'd0;
                    rep_pend_next = 1'b0;
                    rep_val_next  = 8'd0;
                    end_mask_next = '0;
                    running_next  = 16'd0;
                    cursor_next   = '0;
                    xmin_next     = 16'd0;
                    ymin_next     = 16'd0;
                    xmax_next     = 16'd0;
                end
                else
                begin
                    case (cmd.phase)
                        S_HEADER:
                        begin
                            if (!fp_reg[0])
                            begin
                                hold_next = data_byte;
                                fp_next   = fp_reg + 4'd1;
                            end
                            else
                            begin
                                case (fp_reg)
                                    4'd1: contours_next = word;
                                    4'd3: xmin_next     = word;
                                    4'd5: ymin_next     = word;
                                    4'd7: xmax_next     = word;
                                    default: ;
                                endcase
                                if (fp_reg == 4'd9)
                                begin
                                    fp_next  = 4'd0;
                                    out_load = 1'b1;
                                    o_kind   = KIND_BOX;
                                    o_x      = xmin_reg;
                                    o_y      = ymin_reg;
                                    o_xm     = xmax_reg;
                                    o_ym     = word;
                                    o_on     = 1'b0;
                                    o_ce     = 1'b0;
                                    o_idx    = 6'd0;
                                    o_last   = !contours_reg[15] && (contours_reg == 16'd0);
                                end
                                else
                                    fp_next = fp_reg + 4'd1;
                            end
                        end
                        S_ENDS:
                        begin
                            if (!fp_reg[0])
                            begin
                                hold_next = data_byte;
                                fp_next   = 4'd1;
                            end
                            else
                            begin
                                fp_next       = 4'd0;
                                contours_next = contours_reg - 16'd1;
                                if (word < 16'(MAX_POINTS))
                                    end_mask_next[word[IDX_W-1:0]] = 1'b1;
                                if (contours_reg == 16'd1)
                                begin
                                    if (word >= 16'(MAX_POINTS))
                                    begin
                                        out_load = 1'b1;
                                        o_kind   = KIND_OVERFLOW;
                                        o_x      = 16'd0;
                                        o_y      = 16'd0;
                                        o_on     = 1'b0;
                                        o_ce     = 1'b0;
                                        o_idx    = 6'd0;
                                        o_last   = 1'b1;
                                    end
                                    else
                                        total_next = word[CNT_W-1:0] + CNT_W'(1);
                                end
                            end
                        end
                        S_INSLEN:
                        begin
                            if (!fp_reg[0])
                            begin
                                hold_next = data_byte;
                                fp_next   = 4'd1;
                            end
                            else
                            begin
                                fp_next     = 4'd0;
                                skip_next   = word;
                                cursor_next = '0;
                            end
                        end
                        S_SKIP:
                            skip_next = skip_reg - 16'd1;
                        S_FLAGS:
                        begin
                            if (rep_pend_reg)
                                rep_cnt_next = (data_byte > 8'(room)) ? room
                                                                       : data_byte[CNT_W-1:0];
                            else
                            begin
                                if (cursor_reg < total_reg)
                                begin
                                    flag_we     = 1'b1;
                                    cursor_next = cursor_inc;
                                end
                                if (data_byte[3])
                                begin
                                    rep_pend_next = 1'b1;
                                    rep_val_next  = data_byte;
                                end
                            end
                        end
                        S_XS:
                        begin
                            if (!d_short && !fp_reg[0])
                            begin
                                hold_next = data_byte;
                                fp_next   = 4'd1;
                            end
                            else
                            begin
                                fp_next      = 4'd0;
                                running_next = dsum;
                                x_we         = 1'b1;
                                x_wd         = dsum;
                                cursor_next  = cursor_inc;
                            end
                        end
                        S_YS:
                        begin
                            if (!d_short && !fp_reg[0])
                            begin
                                hold_next = data_byte;
                                fp_next   = 4'd1;
                            end
                            else
                            begin
                                fp_next      = 4'd0;
                                running_next = dsum;
                                cursor_next  = cursor_inc;
                                out_load     = 1'b1;
                                o_y          = dsum;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            OP_REPT:
            begin
                if (rep_cnt_reg != '0)
                begin
                    flag_we      = 1'b1;
                    flag_wd      = pack_flag(rep_val_reg);
                    cursor_next  = cursor_inc;
                    rep_cnt_next = rep_cnt_reg - CNT_W'(1);
                end
                else
                    rep_pend_next = 1'b0;
            end
            OP_XINIT, OP_YINIT:
            begin
                running_next = 16'd0;
                cursor_next  = '0;
                fp_next      = 4'd0;
            end
            OP_XRUN:
            begin
                x_we        = 1'b1;
                cursor_next = cursor_inc;
            end
            OP_YRUN:
            begin
                out_load    = 1'b1;
                cursor_next = cursor_inc;
            end
            OP_CMPD:
            begin
                out_load = 1'b1;
                o_kind   = KIND_COMPOUND;
                o_x      = 16'd0;
                o_y      = 16'd0;
                o_on     = 1'b0;
                o_ce     = 1'b0;
                o_idx    = 6'd0;
                o_last   = 1'b1;
            end
            default: ;
        endcase
        out_valid_next = out_load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fp_reg        <= 4'd0;
            hold_reg      <= 8'd0;
            contours_reg  <= 16'd0;
            total_reg     <= '0;
            skip_reg      <= 16'd0;
            rep_pend_reg  <= 1'b0;
            rep_val_reg   <= 8'd0;
            rep_cnt_reg   <= '0;
            end_mask_reg  <= '0;
            running_reg   <= 16'd0;
            cursor_reg    <= '0;
            xmin_reg      <= 16'd0;
            ymin_reg      <= 16'd0;
            xmax_reg      <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fp_reg        <= fp_next;
            hold_reg      <= hold_next;
            contours_reg  <= contours_next;
            total_reg     <= total_next;
            skip_reg      <= skip_next;
            rep_pend_reg  <= rep_pend_next;
            rep_val_reg   <= rep_val_next;
            rep_cnt_reg   <= rep_cnt_next;
            end_mask_reg  <= end_mask_next;
            running_reg   <= running_next;
            cursor_reg    <= cursor_next;
            xmin_reg      <= xmin_next;
            ymin_reg      <= ymin_next;
            xmax_reg      <= xmax_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // point stores, read at the cursor every cycle
    always_ff @(posedge clk)
    begin
        if (flag_we)
            flag_mem[cursor_idx] <= flag_wd;
        if (x_we)
            x_mem[cursor_idx] <= x_wd;
        flag_q_reg <= flag_mem[cursor_idx];
        x_q_reg    <= x_mem[cursor_idx];
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            kind_reg <= o_kind;
            cx_reg   <= o_x;
            cy_reg   <= o_y;
            xm_reg   <= o_xm;
            ym_reg   <= o_ym;
            on_reg   <= o_on;
            ce_reg   <= o_ce;
            idx_reg  <= o_idx;
            last_reg <= o_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign coord_x     = cx_reg;
    assign coord_y     = cy_reg;
    assign box_x_max   = xm_reg;
    assign box_y_max   = ym_reg;
    assign on_curve    = on_reg;
    assign contour_end = ce_reg;
    assign point_index = idx_reg;
    assign last        = last_reg;

endmodule

FILE: hw/rtl/ogpd_checker.sv
module ogpd_sva (
    input logic              clk,
    input logic              rst_n,
    input logic              valid,
    input logic              ready,
    input logic [1:0]        kind,
    input logic signed [15:0] coord_x,
    input logic signed [15:0] coord_y,
    input logic              on_curve,
    input logic              contour_end,
    input logic [5:0]        point_index,
    input logic              last
);
    import ogpd_pkg::*;

    // a stalled result transaction holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(kind) && $stable(coord_x)
                            && $stable(coord_y) && $stable(point_index) && $stable(last))
        else $error("result changed while stalled");

    a_term: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (kind == KIND_COMPOUND || kind == KIND_OVERFLOW)
            |-> last && coord_x == 16'sd0 && coord_y == 16'sd0)
        else $error("compound/overflow result not terminal");

    a_last_pt: assert property (@(posedge clk) disable iff (!rst_n)
        valid && kind == KIND_POINT && last |-> contour_end)
        else $error("final point does not close a contour");

    a_nonpt: assert property (@(posedge clk) disable iff (!rst_n)
        valid && kind != KIND_POINT |-> !on_curve && !contour_end && point_index == 6'd0)
        else $error("point fields set on non-point result");

endmodule

bind outline_glyph_point_decoder_top ogpd_sva u_ogpd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (result.valid),
    .ready       (result.ready),
    .kind        (result.kind),
    .coord_x     (result.coord_x),
    .coord_y     (result.coord_y),
    .on_curve    (result.on_curve),
    .contour_end (result.contour_end),
    .point_index (result.point_index),
    .last        (result.last)
);

FILE: tb/ogpd_checker.sv
`timescale 1ns / 100ps

module ogpd_checker (
    input  logic   clk,
    input  logic   rst_n,
    ogpd_byte_if   glyph,
    ogpd_result_if result,
    output int     fails,
    output int     pending
);
    import ogpd_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] xm;
        logic [15:0] ym;
        logic        on;
        logic        ce;
        logic [5:0]  idx;
        logic        last;
    } point_rec_t;

    point_rec_t  point_q[$];
    int          fail_cnt = 0;
    int          pend_cnt = 0;

    logic [3:0]  phase;
    logic [7:0]  hold;
    logic [3:0]  fpos;
    logic [15:0] contours;
    logic [6:0]  total;
    logic [15:0] skip;
    logic        rep_pend;
    logic [7:0]  rep_flag;
    logic [4:0]  flags [64];
    logic [15:0] xs [64];
    logic [63:0] ends;
    logic [15:0] coord;
    logic [6:0]  cursor;
    logic [15:0] box [3];

    assign fails   = fail_cnt;
    assign pending = pend_cnt;

    function automatic void add_rec(logic [1:0] k, logic [15:0] x, logic [15:0] y,
                                    logic [15:0] xm, logic [15:0] ym, logic on,
                                    logic ce, logic [5:0] idx, logic last);
        point_rec_t r;
        r = '{k, x, y, xm, ym, on, ce, idx, last};
        point_q = {point_q, r};
    endfunction

    function automatic void clear_glyph();
        phase = S_HEADER;
        hold = '0;
        fpos = '0;
        contours = '0;
        total = '0;
        skip = '0;
        rep_pend = 1'b0;
        rep_flag = '0;
        ends = '0;
        coord = '0;
        cursor = '0;
        box[0] = '0;
        box[1] = '0;
        box[2] = '0;
    endfunction

    function automatic void emit_point();
        logic [5:0] i;
        i = cursor[5:0];
        add_rec(KIND_POINT, xs[i], coord, 16'd0, 16'd0, flags[i][0], ends[i], i,
                (int'(i) + 1 == int'(total)));
    endfunction

    function automatic void advance_y();
        while (cursor < total && (flags[cursor[5:0]] & 5'h14) == 5'h10)
        begin
            emit_point();
            cursor++;
        end
        if (cursor >= total)
            phase = S_DONE;
    endfunction

    function automatic void advance_x();
        while (cursor < total && (flags[cursor[5:0]] & 5'h0A) == 5'h08)
        begin
            xs[cursor[5:0]] = coord;
            cursor++;
        end
        if (cursor >= total)
        begin
            phase = S_YS;
            coord = '0;
            cursor = '0;
            fpos = '0;
            advance_y();
        end
    endfunction

    function automatic void start_x();
        phase = S_XS;
        coord = '0;
        cursor = '0;
        fpos = '0;
        advance_x();
    endfunction

    function automatic bit add_delta(logic [7:0] b, bit is_short, bit positive);
        if (is_short)
        begin
            coord = positive ? coord + 16'(b) : coord - 16'(b);
            return 1'b1;
        end
        if (fpos == 4'd0)
        begin
            hold = b;
            fpos = 4'd1;
            return 1'b0;
        end
        coord = coord + {hold, b};
        fpos = 4'd0;
        return 1'b1;
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic gs);
        logic [15:0] word;
        int          cnt;
        int          room;
        logic [4:0]  f;
        logic [3:0]  bpos;
        if (gs)
            clear_glyph();
        case (phase)
            S_HEADER:
            begin
                if (fpos[0] == 1'b0)
                begin
                    hold = b;
                    fpos++;
                end
                else
                begin
                    word = {hold, b};
                    bpos = fpos - 4'd3;
                    if (fpos == 4'd1)
                        contours = word;
                    else if (fpos < 4'd9)
                        box[bpos[2:1]] = word;
                    fpos++;
                    if (fpos >= 4'd10)
                    begin
                        fpos = 4'd0;
                        if (contours[15])
                        begin
                            add_rec(KIND_BOX, box[0], box[1], box[2], word,
                                    1'b0, 1'b0, 6'd0, 1'b0);
                            add_rec(KIND_COMPOUND, 16'd0, 16'd0, 16'd0, 16'd0,
                                    1'b0, 1'b0, 6'd0, 1'b1);
                            phase = S_DONE;
                        end
                        else if (contours == 16'd0)
                        begin
                            add_rec(KIND_BOX, box[0], box[1], box[2], word,
                                    1'b0, 1'b0, 6'd0, 1'b1);
                            phase = S_DONE;
                        end
                        else
                        begin
                            add_rec(KIND_BOX, box[0], box[1], box[2], word,
                                    1'b0, 1'b0, 6'd0, 1'b0);
                            phase = S_ENDS;
                        end
                    end
                end
            end
            S_ENDS:
            begin
                if (fpos == 4'd0)
                begin
                    hold = b;
                    fpos = 4'd1;
                end
                else
                begin
                    fpos = 4'd0;
                    word = {hold, b};
                    if (word < 16'd64)
                        ends[word[5:0]] = 1'b1;
                    contours--;
                    if (contours == 16'd0)
                    begin
                        if (word >= 16'd64)
                        begin
                            add_rec(KIND_OVERFLOW, 16'd0, 16'd0, 16'd0, 16'd0,
                                    1'b0, 1'b0, 6'd0, 1'b1);
                            phase = S_DONE;
                        end
                        else
                        begin
                            total = word[6:0] + 7'd1;
                            phase = S_INSLEN;
                        end
                    end
                end
            end
            S_INSLEN:
            begin
                if (fpos == 4'd0)
                begin
                    hold = b;
                    fpos = 4'd1;
                end
                else
                begin
                    fpos = 4'd0;
                    skip = {hold, b};
                    cursor = '0;
                    phase = (skip != 16'd0) ? S_SKIP : S_FLAGS;
                end
            end
            S_SKIP:
            begin
                skip--;
                if (skip == 16'd0)
                    phase = S_FLAGS;
            end
            S_FLAGS:
            begin
                if (rep_pend)
                begin
                    cnt = int'(b);
                    room = int'(total) - int'(cursor);
                    if (cnt > room)
                        cnt = room;
                    repeat (cnt)
                    begin
                        flags[cursor[5:0]] = {rep_flag[5], rep_flag[4], rep_flag[2:0]};
                        cursor++;
                    end
                    rep_pend = 1'b0;
                    if (cursor >= total)
                        start_x();
                end
                else
                begin
                    if (cursor < total)
                    begin
                        flags[cursor[5:0]] = {b[5], b[4], b[2:0]};
                        cursor++;
                    end
                    if (b[3])
                    begin
                        rep_pend = 1'b1;
                        rep_flag = b;
                    end
                    else if (cursor >= total)
                        start_x();
                end
            end
            S_XS:
            begin
                f = flags[cursor[5:0]];
                if (add_delta(b, f[1], f[3]))
                begin
                    xs[cursor[5:0]] = coord;
                    cursor++;
                    advance_x();
                end
            end
            S_YS:
            begin
                f = flags[cursor[5:0]];
                if (add_delta(b, f[2], f[4]))
                begin
                    emit_point();
                    cursor++;
                    advance_y();
                end
            end
            default: ;
        endcase
    endfunction

    // compare before predicting: a result never leaves in the cycle its byte arrives
    always @(posedge clk)
    begin
        point_rec_t want;
        point_rec_t got;
        if (!rst_n)
            clear_glyph();
        else
        begin
            if (result.valid && result.ready)
            begin
                got = '{result.kind, result.coord_x, result.coord_y, result.box_x_max,
                        result.box_y_max, result.on_curve, result.contour_end,
                        result.point_index, result.last};
                if (point_q.size() == 0)
                begin
                    fail_cnt++;
                    $display("%0t: unexpected result, actual %p", $time, got);
                end
                else
                begin
                    want = point_q.pop_front();
                    if (got !== want)
                    begin
                        fail_cnt++;
                        $display("%0t: mismatch, expected %p actual %p", $time, want, got);
                    end
                end
            end
            if (glyph.valid && glyph.ready)
                decode_byte(glyph.data_byte, glyph.glyph_start);
        end
        pend_cnt = point_q.size();
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import ogpd_pkg::*;

    localparam int LIMIT = 400000;

    typedef struct {
        logic [7:0] b;
        logic       s;
    } glyph_byte_t;

    logic clk = 1'b0;
    logic rst_n;
    int   fails;
    int   pending;
    int   cycles = 0;
    int   mode;
    int   sent;
    bit   mark_next;

    glyph_byte_t byte_q[$];

    ogpd_byte_if   glyph_ch ();
    ogpd_result_if result_ch ();

    outline_glyph_point_decoder_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .glyph  (glyph_ch),
        .result (result_ch)
    );

    ogpd_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .glyph   (glyph_ch),
        .result  (result_ch),
        .fails   (fails),
        .pending (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // receiver stalls in the stalling phases only
    always @(posedge clk)
    begin
        if (mode == 2)
            result_ch.ready <= ($urandom_range(0, 99) >= 46);
        else if (mode == 3)
            result_ch.ready <= ($urandom_range(0, 99) >= 10);
        else
            result_ch.ready <= 1'b1;
    end

    task automatic push_byte(logic [7:0] b);
        glyph_byte_t t;
        t.b = b;
        t.s = mark_next;
        mark_next = 0;
        byte_q = {byte_q, t};
    endtask

    task automatic push_word(logic [15:0] w);
        push_byte(w[15:8]);
        push_byte(w[7:0]);
    endtask

    function automatic logic [15:0] box_word();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_header(logic [15:0] ncont, bit mark);
        mark_next = mark;
        push_word(ncont);
        repeat (4) push_word(box_word());
    endtask

    task automatic push_junk(int n);
        repeat (n) push_byte(8'($urandom));
    endtask

    // well-formed simple glyph; excess may randomly push a repeat count past the points left
    task automatic push_simple(int nc, int npts, int ilen, bit mark, bit excess, bit far_end);
        logic [7:0] fl[$];
        logic [7:0] f;
        int         n;
        int         c;
        int         rem;
        push_header(16'(nc), mark);
        for (int k = 0; k < nc - 1; k++)
            if (far_end && k == 0)
                push_word(16'($urandom_range(64, 65535)));
            else
                push_word(16'($urandom_range(0, npts - 1)));
        push_word(16'(npts - 1));
        push_word(16'(ilen));
        push_junk(ilen);
        n = 0;
        while (n < npts)
        begin
            f = 8'($urandom);
            f[3] = ($urandom_range(0, 3) == 0);
            fl = {fl, f};
            n++;
            push_byte(f);
            if (f[3])
            begin
                rem = npts - n;
                if (excess && $urandom_range(0, 1))
                    c = rem + $urandom_range(1, 255 - rem);
                else
                    c = $urandom_range(0, rem);
                push_byte(8'(c));
                if (c > rem)
                    c = rem;
                repeat (c) fl = {fl, f};
                n += c;
            end
        end
        foreach (fl[i])
            if (fl[i][1])
                push_junk(1);
            else if (!fl[i][4])
                push_junk(2);
        foreach (fl[i])
            if (fl[i][2])
                push_junk(1);
            else if (!fl[i][5])
                push_junk(2);
    endtask

    task automatic random_glyph();
        int sel;
        int npts;
        int start_len;
        int cut;
        sel = $urandom_range(0, 99);
        npts = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
        start_len = byte_q.size();
        if (sel < 8)
        begin
            push_header(16'($urandom_range(16'h8000, 16'hFFFF)), 1);
            push_junk($urandom_range(0, 3));
        end
        else if (sel < 13)
            push_header(16'h0000, 1);
        else if (sel < 18)
        begin
            push_header(16'd1, 1);
            push_word(16'($urandom_range(64, 65535)));
            push_junk($urandom_range(0, 3));
        end
        else
        begin
            push_simple($urandom_range(1, 4), npts, $urandom_range(0, 3), 1,
                        $urandom_range(0, 4) == 0, $urandom_range(0, 9) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                cut = $urandom_range(1, byte_q.size() - start_len - 1);
                repeat (cut) void'(byte_q.pop_back());
            end
            else if ($urandom_range(0, 4) == 0)
                push_junk($urandom_range(1, 3));
        end
    endtask

    task automatic send_all();
        glyph_byte_t t;
        int          idle_pct;
        while (byte_q.size() != 0)
        begin
            t = byte_q.pop_front();
            mode = (sent / 40) % 4;
            idle_pct = (mode == 1) ? 46 : (mode == 3) ? 10 : 0;
            if ($urandom_range(0, 99) < idle_pct)
            begin
                glyph_ch.valid <= 1'b0;
                @(posedge clk);
                while ($urandom_range(0, 99) < idle_pct)
                    @(posedge clk);
            end
            glyph_ch.valid       <= 1'b1;
            glyph_ch.data_byte   <= t.b;
            glyph_ch.glyph_start <= t.s;
            @(posedge clk);
            while (!glyph_ch.ready)
                @(posedge clk);
            sent++;
        end
        glyph_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    initial
    begin
        mode = 0;
        sent = 0;
        rst_n = 0;
        glyph_ch.valid = 0;
        glyph_ch.data_byte = 0;
        glyph_ch.glyph_start = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // first record with no start mark, then the corner cases
        push_simple(2, 5, 2, 0, 0, 0);
        push_header(16'hFFFF, 1);
        push_junk(3);
        push_header(16'h0000, 1);
        push_header(16'd1, 1);
        push_word(16'd64);
        push_header(16'd2, 1);
        push_word(16'd3);
        push_word(16'hFFFF);
        push_junk(2);
        push_simple(2, 6, 1, 1, 1, 1);
        push_junk(4);
        push_simple(1, 1, 0, 1, 0, 0);
        push_simple(2, 8, 3, 1, 0, 0);
        repeat (10) void'(byte_q.pop_back());
        push_simple(1, 4, 0, 1, 1, 0);
        send_all();
        drain();

        while (sent + byte_q.size() < 230)
            random_glyph();
        send_all();

        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/ogpd_pkg.sv
hw/rtl/ogpd_if.sv
hw/rtl/ogpd_ctrl.sv
hw/rtl/ogpd_dp.sv
hw/rtl/outline_glyph_point_decoder_top.sv
hw/rtl/ogpd_checker.sv
tb/ogpd_checker.sv
tb/testbench.sv
